/* hw/rtl/crr_pkg.sv */
// ----------------------------------------------------------------------------
// crr_pkg - shared types and constants for the cascaded range remapper
// Request codes, controller states and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package crr_pkg;

   localparam int DEFAULT_STAGES  = 7;
   localparam int DEFAULT_ENTRIES = 32;

   localparam int VALUE_W = 32;
   localparam int TYPE_W  = 2;
   localparam int STAGE_W = 3;
   localparam int ENTRY_W = 5;

   // packed window word: {valid, len, src, dst}
   localparam int WORD_W = 3 * VALUE_W + 1;

   localparam logic [TYPE_W-1:0] REQ_WRITE   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_MAP     = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RESTART = 2'd2;

   localparam logic [VALUE_W-1:0] ALL_ONES = '1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } crr_state_type;

   typedef struct packed {
      logic clear_step;   // write one zero word of the clearing pass
      logic load;         // transaction accepted on the request channel
      logic finish;       // load the response register
   } crr_cmd_type;

   typedef struct packed {
      logic clear_done;   // last word of the clearing pass is being written
      logic scan_done;    // last window of the last stage is being compared
      logic scan_busy;    // reads or compares still in flight
   } crr_sts_type;

endpackage

/* hw/rtl/crr_ctrl.sv */
// ----------------------------------------------------------------------------
// crr_ctrl - sequencing controller
// Runs the clearing pass, accepts transactions, waits for the window scan
// and owns the response valid flag.
// ----------------------------------------------------------------------------
module crr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [crr_pkg::TYPE_W-1:0]    req_type,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  crr_pkg::crr_sts_type          sts,
   output crr_pkg::crr_cmd_type          cmd
);

   crr_pkg::crr_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crr_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.clear_step = 1'b0;
      cmd.load       = 1'b0;
      cmd.finish     = 1'b0;
      unique case (state_ff)
         crr_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = crr_pkg::ST_IDLE;
            end
         end
         crr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_type == crr_pkg::REQ_MAP) ? crr_pkg::ST_SCAN
                                                         : crr_pkg::ST_FINISH;
            end
         end
         crr_pkg::ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = crr_pkg::ST_FINISH;
            end
         end
         crr_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = crr_pkg::ST_IDLE;
            end
         end
         default: state_in = crr_pkg::ST_CLEAR;
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

/* hw/rtl/crr_datapath.sv */
// ----------------------------------------------------------------------------
// crr_datapath - window store, range compare and running minimum
// One memory holds every window of every stage; the scan reads one window
// per cycle and compares it against the current value in the following cycle.
// ----------------------------------------------------------------------------
module crr_datapath #(
   parameter int STAGES  = crr_pkg::DEFAULT_STAGES,
   parameter int ENTRIES = crr_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  crr_pkg::crr_cmd_type          cmd,
   output crr_pkg::crr_sts_type          sts,
   input  logic [crr_pkg::TYPE_W-1:0]    req_type,
   input  logic [crr_pkg::STAGE_W-1:0]   req_stage_index,
   input  logic [crr_pkg::ENTRY_W-1:0]   req_entry_index,
   input  logic                          req_entry_valid,
   input  logic [crr_pkg::VALUE_W-1:0]   req_dest_start,
   input  logic [crr_pkg::VALUE_W-1:0]   req_src_start,
   input  logic [crr_pkg::VALUE_W-1:0]   req_range_len,
   input  logic [crr_pkg::VALUE_W-1:0]   req_seed_value,
   output logic [crr_pkg::VALUE_W-1:0]   rsp_mapped_value,
   output logic [crr_pkg::VALUE_W-1:0]   rsp_min_value
);

   localparam int SLOTS  = STAGES * ENTRIES;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int VW     = crr_pkg::VALUE_W;
   localparam int WW     = crr_pkg::WORD_W;

   logic [WW-1:0] mem [SLOTS];

   // write port
   logic              mem_we;
   logic [SLOT_W-1:0] mem_addr;
   logic [WW-1:0]     mem_wdata;
   logic              wr_in_range;
   logic [SLOT_W-1:0] wr_slot;
   logic [SLOT_W-1:0] clr_ff, clr_in;

   // scan
   logic              issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ENT_W-1:0]  ent_ff, ent_in;
   logic              cmp_ent_last_ff, cmp_slot_last_ff;
   logic              issue_ent_last, issue_slot_last;
   logic [WW-1:0]     rd_word_ff;
   logic              matched_ff, matched_in;
   logic [VW-1:0]     val_ff, val_in;

   // compare
   logic [VW-1:0]     w_dst, w_src, w_len, diff;
   logic              w_valid, hit;

   // result
   logic [crr_pkg::TYPE_W-1:0] type_ff;
   logic [VW-1:0]     min_ff, min_in;
   logic [VW-1:0]     mapped_ff, mapped_in;
   logic [VW-1:0]     rsp_min_ff;

   // -------------------------------------------------------------------------
   // window writes and clearing pass
   // -------------------------------------------------------------------------
   assign wr_in_range = (32'(req_stage_index) < 32'(STAGES)) &&
                        (32'(req_entry_index) < 32'(ENTRIES));
   assign wr_slot     = SLOT_W'(32'(req_stage_index) * 32'(ENTRIES) +
                                32'(req_entry_index));

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = wr_slot;
      mem_wdata = {req_entry_valid, req_range_len, req_src_start, req_dest_start};
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_addr  = clr_ff;
         mem_wdata = '0;
      end else if (cmd.load && req_type == crr_pkg::REQ_WRITE && wr_in_range) begin
         mem_we = 1'b1;
      end
   end

   assign clr_in = cmd.clear_step ? clr_ff + SLOT_W'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (issue_ff) begin
         rd_word_ff <= mem[slot_ff];
      end
   end

   // -------------------------------------------------------------------------
   // scan sequencing: issue one read per cycle, compare its registered word in the next cycle, not later
   // -------------------------------------------------------------------------
   assign issue_ent_last  = (ent_ff == ENT_W'(ENTRIES - 1));
   assign issue_slot_last = (slot_ff == SLOT_W'(SLOTS - 1));

   always_comb begin
      issue_in = issue_ff;
      slot_in  = slot_ff;
      ent_in   = ent_ff;
      if (cmd.load && req_type == crr_pkg::REQ_MAP) begin
         issue_in = 1'b1;
         slot_in  = '0;
         ent_in   = '0;
      end else if (issue_ff) begin
         issue_in = !issue_slot_last;
         slot_in  = slot_ff + SLOT_W'(1);
         ent_in   = issue_ent_last ? '0 : ent_ff + ENT_W'(1);
      end
   end

   assign pend_in = issue_ff;

   assign w_dst   = rd_word_ff[VW-1:0];
   assign w_src   = rd_word_ff[2*VW-1:VW];
   assign w_len   = rd_word_ff[3*VW-1:2*VW];
   assign w_valid = rd_word_ff[WW-1];
   assign diff    = val_ff - w_src;
   // true interval test: no wrap past the top, zero length never hits
   assign hit     = pend_ff && w_valid && !matched_ff &&
                    (val_ff >= w_src) && (diff < w_len);

   always_comb begin
      val_in     = val_ff;
      matched_in = matched_ff;
      if (cmd.load && req_type == crr_pkg::REQ_MAP) begin
         val_in     = req_seed_value;
         matched_in = 1'b0;
      end else if (pend_ff) begin
         if (hit) begin
            val_in     = w_dst + diff;
            matched_in = 1'b1;
         end
         if (cmp_ent_last_ff) begin
            matched_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         issue_ff   <= 1'b0;
         pend_ff    <= 1'b0;
         matched_ff <= 1'b0;
         min_ff     <= crr_pkg::ALL_ONES;
      end else begin
         clr_ff     <= clr_in;
         issue_ff   <= issue_in;
         pend_ff    <= pend_in;
         matched_ff <= matched_in;
         min_ff     <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff          <= slot_in;
      ent_ff           <= ent_in;
      cmp_ent_last_ff  <= issue_ent_last;
      cmp_slot_last_ff <= issue_slot_last;
      val_ff           <= val_in;
      if (cmd.load) begin
         type_ff <= req_type;
      end
      if (cmd.finish) begin
         mapped_ff  <= mapped_in;
         rsp_min_ff <= min_in;
      end
   end

   // -------------------------------------------------------------------------
   // running minimum and response words
   // -------------------------------------------------------------------------
   always_comb begin
      min_in    = min_ff;
      mapped_in = '0;
      if (cmd.finish) begin
         case (type_ff)
            crr_pkg::REQ_MAP: begin
               mapped_in = val_ff;
               if (val_ff < min_ff) begin
                  min_in = val_ff;
               end
            end
            crr_pkg::REQ_RESTART: min_in = crr_pkg::ALL_ONES;
            default:              min_in = min_ff;
         endcase
      end
   end

   assign sts.clear_done = cmd.clear_step && (clr_ff == SLOT_W'(SLOTS - 1));
   assign sts.scan_done  = pend_ff && cmp_slot_last_ff;
   assign sts.scan_busy  = issue_ff || pend_ff;

   assign rsp_mapped_value = mapped_ff;
   assign rsp_min_value    = rsp_min_ff;

endmodule

/* hw/rtl/cascaded_range_remap.sv */
// ----------------------------------------------------------------------------
// cascaded_range_remap - chain of range-window remap tables
// Loads/clears windows, maps a value through every stage table in order
// and tracks the running minimum of mapped values.
// ----------------------------------------------------------------------------
//
//  channel  | ports   | transaction
//  ---------+---------+---------------------------------------------------
//  request  | req_*   | window write, map value or restart minimum
//  response | rsp_*   | mapped value (zero unless map) and running minimum
//
//  Scan: a map transaction reads one window from the window memory per
//    cycle and compares it the cycle after, through every stage in order;
//    the next transaction is accepted only after the finish step.
//    Write and restart transactions go from accept straight to finish.
//  Reset: a clearing pass writes all STAGES*ENTRIES window words (224 by
//    default) invalid; req_ready stays low until it ends.
//  Stalls: the result sits in an output register; a new result waits in the
//    finish step only while the previous one has not been taken.
//
module cascaded_range_remap #(
   parameter int STAGES  = crr_pkg::DEFAULT_STAGES,
   parameter int ENTRIES = crr_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [crr_pkg::TYPE_W-1:0]    req_type,
   input  logic [crr_pkg::STAGE_W-1:0]   req_stage_index,
   input  logic [crr_pkg::ENTRY_W-1:0]   req_entry_index,
   input  logic                          req_entry_valid,
   input  logic [crr_pkg::VALUE_W-1:0]   req_dest_start,
   input  logic [crr_pkg::VALUE_W-1:0]   req_src_start,
   input  logic [crr_pkg::VALUE_W-1:0]   req_range_len,
   input  logic [crr_pkg::VALUE_W-1:0]   req_seed_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [crr_pkg::VALUE_W-1:0]   rsp_mapped_value,
   output logic [crr_pkg::VALUE_W-1:0]   rsp_min_value
);

   crr_pkg::crr_cmd_type cmd;
   crr_pkg::crr_sts_type sts;

   // controller: clearing pass, accept, scan wait, response handoff
   crr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: window memory, per-window compare, minimum tracking
   crr_datapath #(
      .STAGES  (STAGES),
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_stage_index  (req_stage_index),
      .req_entry_index  (req_entry_index),
      .req_entry_valid  (req_entry_valid),
      .req_dest_start   (req_dest_start),
      .req_src_start    (req_src_start),
      .req_range_len    (req_range_len),
      .req_seed_value   (req_seed_value),
      .rsp_mapped_value (rsp_mapped_value),
      .rsp_min_value    (rsp_min_value)
   );

   // no transaction is taken while the clearing pass runs right after reset
   a_no_accept_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request accepted during clearing pass");

   // a new transaction never enters while a window scan is in flight
   a_ready_not_busy : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !sts.scan_busy)
      else $error("request ready during scan");

   // a result is never loaded over one that is still waiting
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("pending response overwritten");

   // after the scan completes, no read or compare is left in flight
   a_scan_done_once : assert property (@(posedge clock) disable iff (reset)
      sts.scan_done |=> !sts.scan_busy)
      else $error("scan still busy after completion");

endmodule
